### rtl/tpi_pkg.sv
// Shared types and constants for the turtle path interpreter.
// No dependencies; imported by every other file in rtl/.
package tpi_pkg;

   // Parameter defaults
   localparam int STACK_DEPTH_DEFAULT     = 64;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;

   // Register reset values
   localparam logic [31:0] STEP_LENGTH_RESET = 32'd65536;
   localparam logic [15:0] TURN_ANGLE_RESET  = 16'd4551;

   // Heading after reset or restart: 270 degrees as a binary angle
   localparam logic [15:0] HEADING_START = 16'd49152;
   // Quarter turn, turns a sine index into a cosine index
   localparam logic [15:0] QUARTER_TURN  = 16'd16384;

   // Symbol codes
   localparam logic [7:0] SYM_DRAW  = 8'h46;  // 'F'
   localparam logic [7:0] SYM_MOVE  = 8'h66;  // 'f'
   localparam logic [7:0] SYM_LEFT  = 8'h2B;  // '+'
   localparam logic [7:0] SYM_RIGHT = 8'h2D;  // '-'
   localparam logic [7:0] SYM_PUSH  = 8'h5B;  // '['
   localparam logic [7:0] SYM_POP   = 8'h5D;  // ']'

   // CSR register select (byte address bit 2)
   localparam logic REG_STEP_LENGTH = 1'b0;
   localparam logic REG_TURN_ANGLE  = 1'b1;

   typedef enum logic [1:0] {
      KIND_LINE_TO     = 2'd0,
      KIND_MOVE_TO     = 2'd1,
      KIND_STACK_ERROR = 2'd2
   } kind_type;

   // Saved turtle context
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [15:0] h;
   } ctx_type;

   // One result transaction
   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] x_pos;
      logic signed [31:0] y_pos;
   } rsp_type;

endpackage

### rtl/tpi_sine_rom.sv
// Q1.15 sine table with two synchronous read ports (sine and cosine).
// Contents are built at elaboration; depends on tpi_pkg.
module tpi_sine_rom #(
   parameter int SINE_TABLE_BITS = tpi_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic [SINE_TABLE_BITS-1:0] sin_addr,
   input  logic [SINE_TABLE_BITS-1:0] cos_addr,
   output logic signed [15:0]         sin_data,
   output logic signed [15:0]         cos_data
);
   import tpi_pkg::*;

   localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
   localparam int QUARTER    = TABLE_SIZE / 4;
   localparam int QSHIFT     = SINE_TABLE_BITS - 2;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // sin(pi/2 * r / QUARTER) in Q1.15 by a Q30 Taylor series, saturated
   function automatic logic [15:0] quarter_sine(input logic [SINE_TABLE_BITS-1:0] r);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        prod;
      logic signed [63:0] sum;
      x    = (64'(r) * HALF_PI_Q30) >> QSHIFT;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 7; n++) begin
         prod = (term * x2) >> 30;
         // Taylor denominators (2n)(2n+1)
         case (n)
            1:       term = prod / 64'd6;
            2:       term = prod / 64'd20;
            3:       term = prod / 64'd42;
            4:       term = prod / 64'd72;
            5:       term = prod / 64'd110;
            6:       term = prod / 64'd156;
            default: term = prod / 64'd210;
         endcase
         if ((n % 2) == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32767) begin
         sum = 64'sd32767;
      end
      return sum[15:0];
   endfunction

   // Full circle from quarter-wave symmetry
   function automatic logic [TABLE_SIZE*16-1:0] build_rom();
      logic [TABLE_SIZE*16-1:0] rom;
      logic [15:0]              v;
      int                       q;
      int                       r;
      rom = '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         q = i >> QSHIFT;
         r = i & (QUARTER - 1);
         case (q)
            0:       v = quarter_sine(SINE_TABLE_BITS'(r));
            1:       v = quarter_sine(SINE_TABLE_BITS'(QUARTER - r));
            2:       v = -quarter_sine(SINE_TABLE_BITS'(r));
            default: v = -quarter_sine(SINE_TABLE_BITS'(QUARTER - r));
         endcase
         rom[i*16 +: 16] = v;
      end
      return rom;
   endfunction

   localparam logic [TABLE_SIZE*16-1:0] SINE_ROM = build_rom();

   logic signed [15:0] sin_data_ff;
   logic signed [15:0] cos_data_ff;

   // Registered reads
   always_ff @(posedge clock) begin
      sin_data_ff <= SINE_ROM[{sin_addr, 4'b0000} +: 16];
      cos_data_ff <= SINE_ROM[{cos_addr, 4'b0000} +: 16];
   end

   assign sin_data = sin_data_ff;
   assign cos_data = cos_data_ff;

endmodule

### rtl/tpi_ctx_stack.sv
// Context stack memory: one write port, one registered read port.
// Entries are (x, y, heading); depends on tpi_pkg.
module tpi_ctx_stack #(
   parameter int STACK_DEPTH = tpi_pkg::STACK_DEPTH_DEFAULT,
   localparam int AW = $clog2(STACK_DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  tpi_pkg::ctx_type wr_data,
   input  logic [AW-1:0]    rd_addr,
   output tpi_pkg::ctx_type rd_data
);
   import tpi_pkg::*;

   ctx_type mem [STACK_DEPTH];
   ctx_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-edge write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tpi_rsp_fifo.sv
// Two-entry result queue between the datapath and the rsp channel.
// Depends on tpi_pkg for the result transaction type.
module tpi_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tpi_pkg::rsp_type push_data,
   input  logic             pop,
   output logic             out_valid,
   output tpi_pkg::rsp_type out_data,
   output logic [1:0]       count
);
   import tpi_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### rtl/turtle_path_interpreter.sv
// Turtle path interpreter top level: CSRs, turtle state, two-stage datapath.
// Uses tpi_pkg, tpi_sine_rom, tpi_ctx_stack and tpi_rsp_fifo.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+-----------------------
//   req     | req_valid req_stall req_symbol req_restart | symbol transactions in
//   rsp     | rsp_valid rsp_stall rsp_kind rsp_x_pos rsp_y_pos | path events out
//   csr     | csr_psel csr_penable csr_pwrite csr_paddr ... | register access
//
// The accept edge loads the sine table and stack read registers; in the next
// cycle the trig values are scaled by step_length and heading and stack
// update; in the one after the offset is added and the result is queued.
// No new transaction is taken while one is in stage 1. Reset is synchronous
// with no clearing pass; stack contents are not cleared. req_stall also rises
// while the 2-entry result queue is full or filling.
module turtle_path_interpreter #(
   parameter int STACK_DEPTH     = tpi_pkg::STACK_DEPTH_DEFAULT,
   parameter int SINE_TABLE_BITS = tpi_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // symbol input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_symbol,
   input  logic                     req_restart,
   // path output
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tpi_pkg::kind_type        rsp_kind,
   output logic signed [31:0]       rsp_x_pos,
   output logic signed [31:0]       rsp_y_pos,
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import tpi_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int TB = SINE_TABLE_BITS;

   // Configuration registers
   logic [31:0] step_length_ff;
   logic [15:0] turn_angle_ff;

   // Turtle state
   logic [31:0]   x_ff, x_in;
   logic [31:0]   y_ff, y_in;
   logic [15:0]   heading_ff, heading_in;
   logic [CW-1:0] stack_count_ff, stack_count_in;

   // Stage 1: symbol accepted last edge, table and stack data now valid
   logic       s1_valid_ff;
   logic [7:0] s1_symbol_ff;
   logic       s1_restart_ff;

   // Stage 2: scaled offsets and result control
   logic               s2_valid_ff;
   logic               s2_advance_ff, s2_advance_in;
   logic               s2_emit_ff, s2_emit_in;
   kind_type           s2_kind_ff, s2_kind_in;
   logic signed [47:0] prod_x_ff, prod_y_ff;

   logic               req_accept;
   logic               wr_csr;
   logic [15:0]        cos_index;
   logic signed [15:0] sin_val, cos_val;
   logic signed [32:0] step_s;
   logic signed [47:0] prod_x, prod_y;
   logic [31:0]        x_sum, y_sum;
   logic [CW-1:0]      count_dec;
   logic               stack_full;
   logic               stack_empty;
   logic               push_en;
   ctx_type            push_ctx;
   ctx_type            pop_ctx;
   logic               fifo_push;
   logic               fifo_pop;
   rsp_type            fifo_in;
   rsp_type            fifo_out;
   logic [1:0]         fifo_count;

   // Handshakes
   assign req_stall  = s1_valid_ff || (fifo_count == 2'd2)
                       || ((fifo_count == 2'd1) && s2_valid_ff);
   assign req_accept = req_valid && !req_stall;
   assign fifo_pop   = rsp_valid && !rsp_stall;

   // CSR access
   assign csr_pready = 1'b1;
   assign wr_csr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         REG_STEP_LENGTH: csr_prdata = step_length_ff;
         REG_TURN_ANGLE:  csr_prdata = {16'd0, turn_angle_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // Table lookups, addressed from the live heading
   assign cos_index = heading_ff + QUARTER_TURN;

   tpi_sine_rom #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock    (clock),
      .sin_addr (heading_ff[15 -: TB]),
      .cos_addr (cos_index[15 -: TB]),
      .sin_data (sin_val),
      .cos_data (cos_val)
   );

   // Stack memory: read top entry every cycle, write on push
   assign count_dec   = stack_count_ff - CW'(1);
   assign stack_full  = (stack_count_ff >= CW'(STACK_DEPTH));
   assign stack_empty = (stack_count_ff == '0);
   assign push_ctx    = '{x: x_ff, y: y_ff, h: heading_ff};

   tpi_ctx_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_ctx_stack (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (stack_count_ff[AW-1:0]),
      .wr_data (push_ctx),
      .rd_addr (count_dec[AW-1:0]),
      .rd_data (pop_ctx)
   );

   // Stage 1 scaling: trig times step length
   assign step_s = signed'({1'b0, step_length_ff});
   assign prod_x = cos_val * step_s;
   assign prod_y = sin_val * step_s;

   // Stage 2 offsets: floor(p / 32768) is an arithmetic shift
   assign x_sum = x_ff + prod_x_ff[46:15];
   assign y_sum = y_ff + prod_y_ff[46:15];

   // Next turtle state; stage 1 and stage 2 never hold items together
   always_comb begin
      x_in           = x_ff;
      y_in           = y_ff;
      heading_in     = heading_ff;
      stack_count_in = stack_count_ff;
      push_en        = 1'b0;
      s2_advance_in  = 1'b0;
      s2_emit_in     = 1'b0;
      s2_kind_in     = KIND_MOVE_TO;
      if (s2_valid_ff && s2_advance_ff) begin
         x_in = x_sum;
         y_in = y_sum;
      end
      if (s1_valid_ff) begin
         if (s1_restart_ff) begin
            x_in           = 32'd0;
            y_in           = 32'd0;
            heading_in     = HEADING_START;
            stack_count_in = '0;
            s2_emit_in     = 1'b1;
         end else begin
            case (s1_symbol_ff)
               SYM_DRAW: begin
                  s2_advance_in = 1'b1;
                  s2_emit_in    = 1'b1;
                  s2_kind_in    = KIND_LINE_TO;
               end
               SYM_MOVE: begin
                  s2_advance_in = 1'b1;
                  s2_emit_in    = 1'b1;
               end
               SYM_LEFT: begin
                  heading_in = heading_ff + turn_angle_ff;
               end
               SYM_RIGHT: begin
                  heading_in = heading_ff - turn_angle_ff;
               end
               SYM_PUSH: begin
                  if (stack_full) begin
                     s2_emit_in = 1'b1;
                     s2_kind_in = KIND_STACK_ERROR;
                  end else begin
                     push_en        = 1'b1;
                     stack_count_in = stack_count_ff + CW'(1);
                  end
               end
               SYM_POP: begin
                  s2_emit_in = 1'b1;
                  if (stack_empty) begin
                     s2_kind_in = KIND_STACK_ERROR;
                  end else begin
                     stack_count_in = count_dec;
                     x_in           = pop_ctx.x;
                     y_in           = pop_ctx.y;
                     heading_in     = pop_ctx.h;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Control and turtle state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_length_ff <= STEP_LENGTH_RESET;
         turn_angle_ff  <= TURN_ANGLE_RESET;
         x_ff           <= 32'd0;
         y_ff           <= 32'd0;
         heading_ff     <= HEADING_START;
         stack_count_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s2_advance_ff  <= 1'b0;
         s2_emit_ff     <= 1'b0;
      end else begin
         if (wr_csr) begin
            case (csr_paddr[2])
               REG_STEP_LENGTH: step_length_ff <= csr_pwdata;
               REG_TURN_ANGLE:  turn_angle_ff  <= csr_pwdata[15:0];
               default: begin
               end
            endcase
         end
         x_ff           <= x_in;
         y_ff           <= y_in;
         heading_ff     <= heading_in;
         stack_count_ff <= stack_count_in;
         s1_valid_ff    <= req_accept;
         s2_valid_ff    <= s1_valid_ff;
         s2_advance_ff  <= s2_advance_in;
         s2_emit_ff     <= s2_emit_in;
      end
   end

   // Payload pipeline registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_symbol_ff  <= req_symbol;
         s1_restart_ff <= req_restart;
      end
      if (s1_valid_ff) begin
         s2_kind_ff <= s2_kind_in;
         prod_x_ff  <= prod_x;
         prod_y_ff  <= prod_y;
      end
   end

   // Result queue
   assign fifo_push     = s2_valid_ff && s2_emit_ff;
   assign fifo_in.kind  = s2_kind_ff;
   assign fifo_in.x_pos = signed'(s2_advance_ff ? x_sum : x_ff);
   assign fifo_in.y_pos = signed'(s2_advance_ff ? y_sum : y_ff);

   tpi_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_in),
      .pop       (fifo_pop),
      .out_valid (rsp_valid),
      .out_data  (fifo_out),
      .count     (fifo_count)
   );

   assign rsp_kind  = fifo_out.kind;
   assign rsp_x_pos = fifo_out.x_pos;
   assign rsp_y_pos = fifo_out.y_pos;

   // Checks
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stack_count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_stage_exclusive: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !s2_valid_ff)
      else $error("two pipeline stages busy at once");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (fifo_count != 2'd2))
      else $error("result queue overflow");

   a_restart_state: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_restart) |=> ##1
         (heading_ff == HEADING_START && stack_count_ff == '0 && x_ff == 32'd0))
      else $error("restart did not clear turtle state");

endmodule
